/* src/tac_pkg.sv */
// Shared widths, constants and the CORDIC arctangent table for the tilt block.
// Used by every module of the block except tac_cdiv; no dependencies.
package tac_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ANGLE_W      = 16;
  localparam int MAG_W        = 16;
  localparam int SQ_W         = 32;
  localparam int ACC_W        = 24;
  localparam int CNT_W        = 9;
  localparam int BIAS_W       = 15;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int PRESCALE     = 12;
  localparam int CX_W         = 32;
  localparam int Z_W          = 24;
  localparam int SQRT_STEPS   = 16;
  localparam int SQRT_STEP_W  = 4;

  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 16'd9000;

  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 24'sd1152000;
      5'd1:    v = 24'sd680065;
      5'd2:    v = 24'sd359328;
      5'd3:    v = 24'sd182400;
      5'd4:    v = 24'sd91554;
      5'd5:    v = 24'sd45822;
      5'd6:    v = 24'sd22916;
      5'd7:    v = 24'sd11459;
      5'd8:    v = 24'sd5730;
      5'd9:    v = 24'sd2865;
      5'd10:   v = 24'sd1432;
      5'd11:   v = 24'sd716;
      5'd12:   v = 24'sd358;
      5'd13:   v = 24'sd179;
      5'd14:   v = 24'sd90;
      5'd15:   v = 24'sd45;
      5'd16:   v = 24'sd22;
      5'd17:   v = 24'sd11;
      5'd18:   v = 24'sd6;
      5'd19:   v = 24'sd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/tac_if.sv */
// Valid/ready channel interfaces for accelerometer samples and tilt results.
// Depends on tac_pkg for field widths.
interface tac_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic signed [tac_pkg::SAMPLE_W-1:0]    accel_x;
  logic signed [tac_pkg::SAMPLE_W-1:0]    accel_y;
  logic signed [tac_pkg::SAMPLE_W-1:0]    accel_z;
  modport source (output valid, func, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, func, accel_x, accel_y, accel_z, output ready);
endinterface

interface tac_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tac_pkg::ANGLE_W-1:0]     pitch_angle;
  logic signed [tac_pkg::ANGLE_W-1:0]     roll_angle;
  logic                                   calibration_done;
  modport source (output valid, pitch_angle, roll_angle, calibration_done, input ready);
  modport sink (input valid, pitch_angle, roll_angle, calibration_done, output ready);
endinterface

/* src/tac_isqrt.sv */
// Iterative integer square root, one result bit per cycle, rounded down.
// Depends on tac_pkg.
module tac_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tac_pkg::SQ_W-1:0]    value,
  output logic                        done,
  output logic [tac_pkg::MAG_W-1:0]   root
);

  logic [tac_pkg::SQ_W-1:0]        rem;
  logic [tac_pkg::SQ_W-1:0]        res;
  logic [tac_pkg::SQRT_STEP_W-1:0] step;
  logic                            busy;
  logic [tac_pkg::SQ_W-1:0]        bitv;
  logic [tac_pkg::SQ_W-1:0]        trial;

  assign bitv  = 32'h4000_0000 >> {step, 1'b0};
  assign trial = res + bitv;
  assign root  = res[tac_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      rem  <= value;
      res  <= '0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      step <= step + 1'b1;
      if (step == tac_pkg::SQRT_STEP_W'(tac_pkg::SQRT_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

/* src/tac_cordic.sv */
// Vectoring CORDIC giving atan2(num, mag) in hundredths of a degree, one step per cycle.
// Depends on tac_pkg for the arctangent table and widths.
module tac_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tac_pkg::SAMPLE_W-1:0] num,
  input  logic [tac_pkg::MAG_W-1:0]           mag,
  output logic                                done,
  output logic signed [tac_pkg::ANGLE_W-1:0]  angle
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t                          state;
  logic signed [tac_pkg::CX_W-1:0]  x;
  logic signed [tac_pkg::CX_W-1:0]  y;
  logic signed [tac_pkg::Z_W-1:0]   z;
  logic [tac_pkg::STEP_W-1:0]       step;
  logic                             zero_num;
  logic signed [tac_pkg::CX_W-1:0]  xs;
  logic signed [tac_pkg::CX_W-1:0]  ys;
  logic signed [tac_pkg::Z_W-1:0]   atan_v;
  logic [tac_pkg::Z_W-1:0]          zabs;
  logic [tac_pkg::Z_W-1:0]          zrnd;
  logic [tac_pkg::ANGLE_W-1:0]      qmag;
  logic [tac_pkg::ANGLE_W-1:0]      qclamp;

  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign atan_v = tac_pkg::atan_entry(step);
  assign zabs   = z[tac_pkg::Z_W-1] ? tac_pkg::Z_W'(-z) : tac_pkg::Z_W'(z);
  assign zrnd   = (zabs + 24'd128) >> 8;
  assign qmag   = zrnd[tac_pkg::ANGLE_W-1:0];
  assign qclamp = (qmag > tac_pkg::ANGLE_LIMIT) ? tac_pkg::ANGLE_LIMIT : qmag;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= C_IDLE;
      step  <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            x        <= $signed({4'b0, mag, 12'b0});
            y        <= $signed({{4{num[tac_pkg::SAMPLE_W-1]}}, num, 12'b0});
            z        <= '0;
            step     <= '0;
            zero_num <= (num == '0);
            state    <= C_RUN;
          end
        end
        C_RUN: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_v;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_v;
          end
          step <= step + 1'b1;
          if (step == tac_pkg::STEP_W'(tac_pkg::CORDIC_STEPS - 1)) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          if (zero_num) begin
            angle <= '0;
          end else if (z[tac_pkg::Z_W-1]) begin
            angle <= $signed(-qclamp);
          end else begin
            angle <= $signed(qclamp);
          end
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

/* src/tac_cdiv.sv */
// Divider by a fixed divisor using a reciprocal multiplication; the result is ready in the cycle after start.
// Depends on nothing beyond its parameters.
module tac_cdiv #(
  parameter int DIVISOR = 20,
  parameter int DW      = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  // The shift is wide enough that the rounded-up reciprocal gives the exact floor
  // for every dividend below 2^DW.
  localparam int SHIFT = DW + $clog2(DIVISOR);
  localparam int MW    = DW + 2;
  localparam int PW    = SHIFT + DW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

  logic [PW-1:0] prod;

  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      quotient <= prod[SHIFT +: DW];
    end
  end

endmodule

/* src/accel_tilt_angle_with_calibration.sv */
// Top level of the accelerometer tilt block: sequencer, squaring multiplier and calibration.
// Depends on tac_pkg, tac_if, tac_isqrt, tac_cordic and tac_cdiv.
//
// Each sample transaction yields one result transaction carrying pitch and roll in
// hundredths of a degree. The block handles one sample at a time: three squarings on
// one multiplier, then per angle a square root and a CORDIC, after which the result
// is registered to the output and the block returns to idle to take the next sample.
// The calibration sample that completes a run of CAL_SAMPLES adds two reciprocal
// divisions for the mean offsets. A new sample is taken while a result still waits
// to be read; the next result then holds the block until the waiting one has been read.
module accel_tilt_angle_with_calibration #(
  parameter int CAL_SAMPLES = 20
) (
  input  logic     clk,
  input  logic     rst,
  tac_in_if.sink   acc_in,
  tac_out_if.source angle_out
);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQRT, S_CORD, S_CAL, S_DIV, S_OUT} state_t;

  state_t                                 state;
  logic                                   second;
  logic [1:0]                             sq_cnt;
  logic                                   func_r;
  logic signed [tac_pkg::SAMPLE_W-1:0]    ax;
  logic signed [tac_pkg::SAMPLE_W-1:0]    ay;
  logic signed [tac_pkg::SAMPLE_W-1:0]    az;
  logic [tac_pkg::SQ_W-1:0]               sx;
  logic [tac_pkg::SQ_W-1:0]               sy;
  logic [tac_pkg::SQ_W-1:0]               sz;
  logic signed [tac_pkg::ANGLE_W-1:0]     pitch;
  logic signed [tac_pkg::ANGLE_W-1:0]     roll;
  logic signed [tac_pkg::ACC_W-1:0]       pitch_accumulator;
  logic signed [tac_pkg::ACC_W-1:0]       roll_accumulator;
  logic [tac_pkg::CNT_W-1:0]              sample_counter;
  logic signed [tac_pkg::BIAS_W-1:0]      pitch_bias;
  logic signed [tac_pkg::BIAS_W-1:0]      roll_bias;
  logic                                   done_r;

  logic signed [tac_pkg::SAMPLE_W-1:0]    mul_op;
  logic signed [tac_pkg::SQ_W-1:0]        prod;
  logic [tac_pkg::CNT_W-1:0]              cnt_next;
  logic signed [tac_pkg::ACC_W-1:0]       pacc_next;
  logic signed [tac_pkg::ACC_W-1:0]       racc_next;
  logic signed [tac_pkg::ACC_W-1:0]       div_src;
  logic [tac_pkg::ACC_W-1:0]              div_in;
  logic [tac_pkg::BIAS_W-1:0]             qbias;
  logic signed [tac_pkg::BIAS_W-1:0]      bias_val;

  logic                                   sqrt_start;
  logic                                   sqrt_done;
  logic [tac_pkg::MAG_W-1:0]              sqrt_root;
  logic                                   cord_start;
  logic                                   cord_done;
  logic signed [tac_pkg::ANGLE_W-1:0]     cord_angle;
  logic                                   div_start;
  logic                                   div_done;
  logic [tac_pkg::ACC_W-1:0]              div_q;

  assign acc_in.ready = (state == S_IDLE);

  always_comb begin
    case (sq_cnt)
      2'd0:    mul_op = ax;
      2'd1:    mul_op = ay;
      default: mul_op = az;
    endcase
  end

  assign prod      = mul_op * mul_op;
  assign cnt_next  = sample_counter + 1'b1;
  assign pacc_next = pitch_accumulator + tac_pkg::ACC_W'(pitch);
  assign racc_next = roll_accumulator + tac_pkg::ACC_W'(roll);
  assign div_src   = second ? roll_accumulator : pitch_accumulator;
  assign div_in    = (div_src[tac_pkg::ACC_W-1] ? tac_pkg::ACC_W'(-div_src)
                                                : tac_pkg::ACC_W'(div_src))
                     + tac_pkg::ACC_W'(CAL_SAMPLES / 2);
  assign qbias     = div_q[tac_pkg::BIAS_W-1:0];
  assign bias_val  = div_src[tac_pkg::ACC_W-1] ? $signed(-qbias) : $signed(qbias);

  tac_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (second ? (sx + sz) : (sy + sz)),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  tac_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .num   (second ? ay : ax),
    .mag   (sqrt_root),
    .done  (cord_done),
    .angle (cord_angle)
  );

  tac_cdiv #(
    .DIVISOR (CAL_SAMPLES),
    .DW      (tac_pkg::ACC_W)
  ) u_cdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    sqrt_start <= 1'b0;
    cord_start <= 1'b0;
    div_start  <= 1'b0;
    if (rst) begin
      state             <= S_IDLE;
      second            <= 1'b0;
      sq_cnt            <= '0;
      pitch_accumulator <= '0;
      roll_accumulator  <= '0;
      sample_counter    <= '0;
      pitch_bias        <= '0;
      roll_bias         <= '0;
      angle_out.valid   <= 1'b0;
    end else begin
      if (state == S_OUT && (!angle_out.valid || angle_out.ready)) begin
        angle_out.valid <= 1'b1;
      end else if (angle_out.valid && angle_out.ready) begin
        angle_out.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in.valid) begin
            func_r <= acc_in.func;
            ax     <= acc_in.accel_x;
            ay     <= acc_in.accel_y;
            az     <= acc_in.accel_z;
            sq_cnt <= '0;
            second <= 1'b0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          case (sq_cnt)
            2'd0:    sx <= $unsigned(prod);
            2'd1:    sy <= $unsigned(prod);
            default: sz <= $unsigned(prod);
          endcase
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 2'd2) begin
            sqrt_start <= 1'b1;
            state      <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            cord_start <= 1'b1;
            state      <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            if (!second) begin
              pitch      <= cord_angle;
              second     <= 1'b1;
              sqrt_start <= 1'b1;
              state      <= S_SQRT;
            end else begin
              roll  <= cord_angle;
              state <= S_CAL;
            end
          end
        end
        S_CAL: begin
          done_r <= 1'b0;
          state  <= S_OUT;
          if (func_r) begin
            pitch_accumulator <= pacc_next;
            roll_accumulator  <= racc_next;
            sample_counter    <= cnt_next;
            if (cnt_next >= tac_pkg::CNT_W'(CAL_SAMPLES)) begin
              second    <= 1'b0;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!second) begin
              pitch_bias <= bias_val;
              second     <= 1'b1;
              div_start  <= 1'b1;
            end else begin
              roll_bias         <= bias_val;
              pitch_accumulator <= '0;
              roll_accumulator  <= '0;
              sample_counter    <= '0;
              done_r            <= 1'b1;
              state             <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!angle_out.valid || angle_out.ready) begin
            angle_out.calibration_done <= done_r;
            if (func_r) begin
              angle_out.pitch_angle <= pitch;
              angle_out.roll_angle  <= roll;
            end else begin
              angle_out.pitch_angle <= pitch - tac_pkg::ANGLE_W'(pitch_bias);
              angle_out.roll_angle  <= roll - tac_pkg::ANGLE_W'(roll_bias);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/tac_tb_if.sv */
// Packed transaction types for the testbench scoreboard.
// Depends on tac_pkg for field widths.
package tac_tb_types;
  typedef struct packed {
    logic                                func;
    logic signed [tac_pkg::SAMPLE_W-1:0] x;
    logic signed [tac_pkg::SAMPLE_W-1:0] y;
    logic signed [tac_pkg::SAMPLE_W-1:0] z;
  } sample_t;
  typedef struct packed {
    logic signed [tac_pkg::ANGLE_W-1:0] pitch;
    logic signed [tac_pkg::ANGLE_W-1:0] roll;
    logic                               done;
  } angles_t;
endpackage

/* tb/testbench.sv */
// Testbench for the accelerometer tilt block: random and directed samples, a tilt
// predictor with calibration state, and an in-order result checker.
// Depends on tac_pkg, tac_tb_types, tac_if and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CAL = 20;

  class tilt_scoreboard;
    tac_tb_types::angles_t pending[$];
    longint pitch_sum, roll_sum;
    int cal_count, pitch_off, roll_off;
    int errors;

    function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function longint round_div(longint n, longint d);
      longint a, q;
      a = n < 0 ? -n : n;
      q = (a + d / 2) / d;
      return n < 0 ? -q : q;
    endfunction

    function longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'd1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function int angle_of(longint num, longint mag);
      longint cx, cy, cz, xs, ys, r;
      if (num == 0) return 0;
      cx = mag <<< tac_pkg::PRESCALE;
      cy = num <<< tac_pkg::PRESCALE;
      cz = 0;
      for (int i = 0; i < tac_pkg::CORDIC_STEPS; i++) begin
        xs = shr(cx, i);
        ys = shr(cy, i);
        if (cy > 0) begin
          cx = cx + ys;
          cy = cy - xs;
          cz = cz + longint'(tac_pkg::atan_entry(i[tac_pkg::STEP_W-1:0]));
        end else begin
          cx = cx - ys;
          cy = cy + xs;
          cz = cz - longint'(tac_pkg::atan_entry(i[tac_pkg::STEP_W-1:0]));
        end
      end
      r = round_div(cz, 256);
      if (r > 9000) r = 9000;
      if (r < -9000) r = -9000;
      return int'(r);
    endfunction

    function void note_sample(tac_tb_types::sample_t s);
      longint ax, ay, az;
      int p, r;
      tac_tb_types::angles_t e;
      ax = s.x;
      ay = s.y;
      az = s.z;
      p = angle_of(ax, int_sqrt((ay * ay + az * az) & 64'hFFFF_FFFF));
      r = angle_of(ay, int_sqrt((ax * ax + az * az) & 64'hFFFF_FFFF));
      e.done = 1'b0;
      if (s.func) begin
        pitch_sum += p;
        roll_sum += r;
        cal_count = (cal_count + 1) % 512;
        if (cal_count >= N_CAL) begin
          pitch_off = int'(round_div(pitch_sum, N_CAL));
          roll_off = int'(round_div(roll_sum, N_CAL));
          pitch_sum = 0;
          roll_sum = 0;
          cal_count = 0;
          e.done = 1'b1;
        end
        e.pitch = tac_pkg::ANGLE_W'(p);
        e.roll = tac_pkg::ANGLE_W'(r);
      end else begin
        e.pitch = tac_pkg::ANGLE_W'(p - pitch_off);
        e.roll = tac_pkg::ANGLE_W'(r - roll_off);
      end
      pending.push_back(e);
    endfunction

    function void check_result(tac_tb_types::angles_t a);
      tac_tb_types::angles_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.pitch !== e.pitch) begin
        $error("pitch_angle expected %0d actual %0d", e.pitch, a.pitch);
        errors++;
      end
      if (a.roll !== e.roll) begin
        $error("roll_angle expected %0d actual %0d", e.roll, a.roll);
        errors++;
      end
      if (a.done !== e.done) begin
        $error("calibration_done expected %0b actual %0b", e.done, a.done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  tac_in_if acc_in ();
  tac_out_if angle_out ();
  tilt_scoreboard board;
  int hold_off;
  int burst_left;

  accel_tilt_angle_with_calibration #(.CAL_SAMPLES(N_CAL)) u_top (
    .clk(clk),
    .rst(rst),
    .acc_in(acc_in.sink),
    .angle_out(angle_out.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && acc_in.valid && acc_in.ready) begin
      board.note_sample({acc_in.func, acc_in.accel_x, acc_in.accel_y, acc_in.accel_z});
    end
    if (!rst && angle_out.valid && angle_out.ready) begin
      board.check_result({angle_out.pitch_angle, angle_out.roll_angle,
                          angle_out.calibration_done});
    end
  end

  initial begin
    angle_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        angle_out.ready <= 1'b0;
      end else begin
        angle_out.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_sample(logic f, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    if (burst_left == 0) begin
      acc_in.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    acc_in.valid <= 1'b1;
    acc_in.func <= f;
    acc_in.accel_x <= x;
    acc_in.accel_y <= y;
    acc_in.accel_z <= z;
    @(posedge clk);
    while (!acc_in.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return $signed(16'($urandom_range(0, 200))) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    acc_in.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    int rounds;
    logic signed [15:0] g;
    board = new();
    hold_off = 0;
    burst_left = 0;
    rst = 1'b1;
    acc_in.valid = 1'b0;
    acc_in.func = 1'b0;
    acc_in.accel_x = '0;
    acc_in.accel_y = '0;
    acc_in.accel_z = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(1'b0, 16'sh8000, 16'sd0, 16'sd0);
    send_sample(1'b0, 16'sh7FFF, 16'sd0, 16'sd0);
    send_sample(1'b0, 16'sd0, 16'sh8000, 16'sd0);
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sh7FFF);
    send_sample(1'b0, 16'sd1, -16'sd1, 16'sd0);
    send_sample(1'b1, 16'sd500, -16'sd300, 16'sd16000);
    send_sample(1'b0, 16'sd500, -16'sd300, 16'sd16000);
    for (int i = 0; i < 14; i++) begin
      send_sample(1'b1, 16'sh7FFF, 16'sh8000, 16'sd0);
    end
    wait_drained();

    fork
      begin
        hold_off = 300;
        for (int i = 0; i < 10; i++) begin
          send_sample(1'b0, rand_axis(), rand_axis(), rand_axis());
        end
      end
    join
    wait_drained();

    rounds = 0;
    while (rounds < 420) begin
      if ($urandom_range(0, 2) == 0) begin
        g = rand_axis();
        for (int k = 0; k < N_CAL; k++) begin
          send_sample(1'b1, g + 16'($urandom_range(0, 40)) - 16'sd20,
                      rand_axis(), 16'sd16384);
          if ($urandom_range(0, 15) == 0) begin
            send_sample(1'b0, rand_axis(), rand_axis(), rand_axis());
          end
        end
        rounds += N_CAL;
      end else begin
        for (int k = 0; k < 10; k++) begin
          send_sample($urandom_range(0, 4) == 0, rand_axis(), rand_axis(), rand_axis());
        end
        rounds += 10;
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
src/tac_pkg.sv
src/tac_if.sv
src/tac_isqrt.sv
src/tac_cordic.sv
src/tac_cdiv.sv
src/accel_tilt_angle_with_calibration.sv
tb/tac_tb_if.sv
tb/testbench.sv
